@@ design/tkht_pkg.sv @@
package tkht_pkg;

  // Multiplicative hash constants: 0.618... and 0.279... as 0.32 fractions.
  localparam logic [31:0] HASH_C1 = 32'd2654435769;
  localparam logic [31:0] HASH_C2 = 32'd1200244469;

  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_NO_ROOM  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    mul;
    logic    sum;
    logic    idx;
    logic    rd_head;
    logic    rd_ent_head;
    logic    rd_ent_next;
    logic    adv_prev;
    logic    pop;
    logic    take_pop;
    logic    take_mark;
    logic    wr_ent;
    logic    link_new;
    logic    unlink;
    logic    grab;
    logic    st_we;
    status_e st_val;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       head_valid;
    logic       link_valid;
    logic       key_match;
    logic       free_nonempty;
    logic       mark_avail;
    logic [1:0] op;
  } stat_t;

endpackage

@@ design/tkht_ram.sv @@
module tkht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tkht_ctrl.sv @@
module tkht_ctrl import tkht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_MUL     = 13'b0000000000100,
    S_SUM     = 13'b0000000001000,
    S_IDX     = 13'b0000000010000,
    S_HEAD    = 13'b0000000100000,
    S_CHKHEAD = 13'b0000001000000,
    S_CMP     = 13'b0000010000000,
    S_POPWAIT = 13'b0000100000000,
    S_WRENT   = 13'b0001000000000,
    S_LINK    = 13'b0010000000000,
    S_DONE    = 13'b0100000000000,
    S_SPARE   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   walk_miss, walk_hit;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.st_val = ST_MISS;
    walk_miss = 1'b0;
    walk_hit  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_IDX;
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_CHKHEAD;
      end
      S_CHKHEAD: begin
        if (stat_i.head_valid) begin
          cmd_o.rd_ent_head = 1'b1;
          state_d           = S_CMP;
        end else begin
          walk_miss = 1'b1;
        end
      end
      S_CMP: begin
        if (stat_i.key_match) begin
          walk_hit = 1'b1;
        end else if (stat_i.link_valid) begin
          cmd_o.rd_ent_next = 1'b1;
        end else begin
          cmd_o.adv_prev = 1'b1;
          walk_miss      = 1'b1;
        end
      end
      S_POPWAIT: begin
        cmd_o.take_pop = 1'b1;
        state_d        = S_WRENT;
      end
      S_WRENT: begin
        cmd_o.wr_ent = 1'b1;
        state_d      = S_LINK;
      end
      S_LINK: begin
        cmd_o.link_new = 1'b1;
        cmd_o.st_we    = 1'b1;
        cmd_o.st_val   = ST_INSERTED;
        state_d        = S_DONE;
      end
      S_DONE: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // The end of the chain was reached without a match.
    if (walk_miss) begin
      if (stat_i.op == OP_INSERT) begin
        if (stat_i.free_nonempty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_POPWAIT;
        end else if (stat_i.mark_avail) begin
          cmd_o.take_mark = 1'b1;
          state_d         = S_WRENT;
        end else begin
          cmd_o.st_we  = 1'b1;
          cmd_o.st_val = ST_NO_ROOM;
          state_d      = S_DONE;
        end
      end else begin
        cmd_o.st_we  = 1'b1;
        cmd_o.st_val = ST_MISS;
        state_d      = S_DONE;
      end
    end

    // Both keys matched the entry under inspection.
    if (walk_hit) begin
      cmd_o.st_we = 1'b1;
      state_d     = S_DONE;
      case (stat_i.op)
        OP_INSERT: cmd_o.st_val = ST_PRESENT;
        OP_LOOKUP: begin
          cmd_o.st_val = ST_HIT;
          cmd_o.grab   = 1'b1;
        end
        OP_REMOVE: begin
          cmd_o.st_val = ST_HIT;
          cmd_o.grab   = 1'b1;
          cmd_o.unlink = 1'b1;
        end
        default: cmd_o.st_val = ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ design/tkht_dp.sv @@
module tkht_dp import tkht_pkg::*; #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned ENTRIES    = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  output stat_t                              stat_o,
  input  logic [CFG_W-1:0]                   cfg_buckets_i,
  input  logic [1:0]                         kind_i,
  input  logic [31:0]                        first_key_i,
  input  logic [31:0]                        second_key_i,
  input  logic [DATA_WIDTH-1:0]              data_in_i,
  output logic                               done_o,
  output logic [2:0]                         status_o,
  output logic [DATA_WIDTH-1:0]              data_out_o,
  output logic [$clog2(ENTRIES+1)-1:0]       entry_total_o
);

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned NW = $clog2(BUCKETS + 1);

  logic [31:0]           k1_q, k2_q, p1_q, p2_q, h_q;
  logic [DATA_WIDTH-1:0] din_q, dout_q;
  logic [1:0]            op_q;
  logic [BW-1:0]         bkt_q, clr_q;
  logic                  prev_head_q;
  logic [SW-1:0]         prev_q, cur_q, ns_q;
  logic [CW-1:0]         depth_q, mark_q, count_q, depth_m1;
  status_e               res_q;
  logic                  done_q;

  logic [NW-1:0]         n_w;
  logic [31+NW:0]        prod_w;
  logic [SW:0]           head_rdata, link_rdata, head_wdata, link_wdata;
  logic [63:0]           key_rdata;
  logic [DATA_WIDTH-1:0] data_rdata;
  logic [SW-1:0]         free_rdata, ent_addr, link_waddr;
  logic [BW-1:0]         head_waddr;
  logic                  head_we, link_we;

  // Bucket count in use: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_buckets_i == '0) begin
      n_w = NW'(1);
    end else if (32'(cfg_buckets_i) > 32'(BUCKETS)) begin
      n_w = NW'(BUCKETS);
    end else begin
      n_w = NW'(cfg_buckets_i);
    end
  end

  assign prod_w   = (32+NW)'(h_q) * (32+NW)'(n_w);
  assign depth_m1 = depth_q - CW'(1);
  assign ent_addr = cmd_i.rd_ent_head ? head_rdata[SW-1:0] : link_rdata[SW-1:0];

  assign head_we    = cmd_i.clr_step | ((cmd_i.link_new | cmd_i.unlink) & prev_head_q);
  assign head_waddr = cmd_i.clr_step ? clr_q : bkt_q;
  assign head_wdata = cmd_i.clr_step ? '0 : (cmd_i.link_new ? {1'b1, ns_q} : link_rdata);

  assign link_we    = cmd_i.wr_ent | ((cmd_i.link_new | cmd_i.unlink) & ~prev_head_q);
  assign link_waddr = cmd_i.wr_ent ? ns_q : prev_q;
  assign link_wdata = cmd_i.wr_ent ? '0 : (cmd_i.link_new ? {1'b1, ns_q} : link_rdata);

  tkht_ram #(.WIDTH(SW+1), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(cmd_i.rd_head), .raddr_i(bkt_q), .rdata_o(head_rdata)
  );

  tkht_ram #(.WIDTH(SW+1), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(cmd_i.rd_ent_head | cmd_i.rd_ent_next), .raddr_i(ent_addr),
    .rdata_o(link_rdata)
  );

  tkht_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i, .we_i(cmd_i.wr_ent), .waddr_i(ns_q), .wdata_i({k1_q, k2_q}),
    .re_i(cmd_i.rd_ent_head | cmd_i.rd_ent_next), .raddr_i(ent_addr),
    .rdata_o(key_rdata)
  );

  tkht_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_data_ram (
    .clk_i, .we_i(cmd_i.wr_ent), .waddr_i(ns_q), .wdata_i(din_q),
    .re_i(cmd_i.rd_ent_head | cmd_i.rd_ent_next), .raddr_i(ent_addr),
    .rdata_o(data_rdata)
  );

  tkht_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_free_ram (
    .clk_i, .we_i(cmd_i.unlink), .waddr_i(depth_q[SW-1:0]), .wdata_i(cur_q),
    .re_i(cmd_i.pop), .raddr_i(depth_m1[SW-1:0]), .rdata_o(free_rdata)
  );

  // Request payload, hash pipeline and chain walk pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k1_q  <= first_key_i;
      k2_q  <= second_key_i;
      din_q <= data_in_i;
      op_q  <= kind_i;
    end
    if (cmd_i.mul) begin
      p1_q <= 32'(k1_q * HASH_C1);
      p2_q <= 32'(k2_q * HASH_C2);
    end
    if (cmd_i.sum)  h_q   <= p1_q + p2_q;
    if (cmd_i.idx)  bkt_q <= prod_w[32 +: BW];
    if (cmd_i.rd_head) prev_head_q <= 1'b1;
    if (cmd_i.rd_ent_head) cur_q <= ent_addr;
    if (cmd_i.rd_ent_next) begin
      prev_q      <= cur_q;
      prev_head_q <= 1'b0;
      cur_q       <= ent_addr;
    end
    if (cmd_i.adv_prev) begin
      prev_q      <= cur_q;
      prev_head_q <= 1'b0;
    end
    if (cmd_i.take_mark) ns_q <= mark_q[SW-1:0];
    if (cmd_i.take_pop)  ns_q <= free_rdata;
    if (cmd_i.st_we) res_q <= cmd_i.st_val;
    if (cmd_i.load) begin
      dout_q <= '0;
    end else if (cmd_i.grab) begin
      dout_q <= data_rdata;
    end
  end

  // Pool bookkeeping and the head clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      mark_q  <= '0;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
      if (cmd_i.clr_step) clr_q <= clr_q + BW'(1);
      if (cmd_i.pop) depth_q <= depth_m1;
      if (cmd_i.take_mark) mark_q <= mark_q + CW'(1);
      if (cmd_i.wr_ent) count_q <= count_q + CW'(1);
      if (cmd_i.unlink) begin
        depth_q <= depth_q + CW'(1);
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign stat_o.clr_last      = (clr_q == BW'(BUCKETS - 1));
  assign stat_o.head_valid    = head_rdata[SW];
  assign stat_o.link_valid    = link_rdata[SW];
  assign stat_o.key_match     = (key_rdata == {k1_q, k2_q});
  assign stat_o.free_nonempty = (depth_q != '0);
  assign stat_o.mark_avail    = (mark_q < CW'(ENTRIES));
  assign stat_o.op            = op_q;

  assign done_o        = done_q;
  assign status_o      = res_q;
  assign data_out_o    = dout_q;
  assign entry_total_o = count_q;

endmodule

@@ design/two_key_chained_hash_table.sv @@
// From an accepted start a request runs the load, multiply, sum, index and head-read states,
// then compares the chain entries one at a time through the registered read of the entry
// memories; an insert that allocates adds the entry-write and link states, and a pop wait
// state when the slot comes off the free stack. busy_o falls with done_o, so the next request
// may start in the strobe cycle.
// After reset the block sweeps every bucket head to clear it, busy high.
module two_key_chained_hash_table import tkht_pkg::*; #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned ENTRIES    = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Request channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic signed [31:0]           first_key_i,
  input  logic signed [31:0]           second_key_i,
  input  logic [DATA_WIDTH-1:0]        data_in_i,
  // Result channel: one strobed cycle per request, no back pressure.
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [DATA_WIDTH-1:0]        data_out_o,
  output logic [$clog2(ENTRIES+1)-1:0] entry_total_o
);

  cmd_t             cmd;
  stat_t            stat;
  logic [CFG_W-1:0] buckets_q;
  logic             cfg_wr;

  // The single register, buckets_in_use, sits at byte address zero. Any write that
  // lands elsewhere is ignored and any read elsewhere returns zero.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == '0);
  assign prdata = (paddr == '0) ? 32'(buckets_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buckets_q <= CFG_RESET;
    end else if (cfg_wr) begin
      buckets_q <= pwdata[CFG_W-1:0];
    end
  end

  // The controller sequences hashing, the chain walk and the pool update.
  tkht_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The datapath holds the hash pipeline, the memories and the pool counters.
  tkht_dp #(
    .BUCKETS    (BUCKETS),
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_buckets_i (buckets_q),
    .kind_i,
    .first_key_i   (first_key_i),
    .second_key_i  (second_key_i),
    .data_in_i,
    .done_o,
    .status_o,
    .data_out_o,
    .entry_total_o
  );

endmodule

@@ design/tkht_chk.sv @@
module tkht_chk import tkht_pkg::*; #(
  parameter int unsigned ENTRIES = 1024
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [2:0]                   status_o,
  input logic [$clog2(ENTRIES+1)-1:0] entry_total_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("more than one result for a request");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_INSERTED) |-> (entry_total_o != '0))
    else $error("insert reported with an empty table");

endmodule

bind two_key_chained_hash_table tkht_chk #(.ENTRIES(ENTRIES)) u_tkht_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_total_o (entry_total_o)
);
